// ===== hw/rtl/ecfl_pkg.sv =====
// Shared types, codes and constants of the CFL maximum signal speed reducer.
package ecfl_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQ_W          = 62;
  localparam int REM_W         = 34;
  localparam int ACC_W         = 96;
  localparam int SQRT_STEPS    = SQ_W / 2;
  localparam int GAMMA_FRAC    = 12;
  localparam int EK_CAP_BIT    = 48;
  localparam int DIFF_CAP_BIT  = 47;

  localparam logic [30:0] MAX31       = 31'h7FFF_FFFF;
  localparam logic [13:0] GAMMA_RST   = 14'd6827;
  localparam logic [14:0] GAMMA_ONE   = 15'd4096;
  localparam logic [30:0] P_FLOOR_RST = 31'd1;

  typedef enum logic [1:0] {
    CFG_GAMMA      = 2'd0,
    CFG_SPEED_MODE = 2'd1,
    CFG_CLAMP      = 2'd2,
    CFG_FLOOR      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_VX_GO,
    ST_VX_WAIT,
    ST_VY_GO,
    ST_VY_WAIT,
    ST_VZ_GO,
    ST_VZ_WAIT,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SUM_Z,
    ST_EK_LO,
    ST_EK_HI,
    ST_EK_ACC,
    ST_DIFF,
    ST_PR_LO,
    ST_PR_HI,
    ST_PR_ACC,
    ST_PRES,
    ST_R_GO,
    ST_R_WAIT,
    ST_X_LO,
    ST_X_HI,
    ST_X_ACC,
    ST_X_CHK,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_CAND,
    ST_FINISH
  } state_t;

endpackage

// ===== hw/rtl/euler_cfl_max_speed_reduce.sv =====
// Top level: running maximum of the CFL signal speed over a set of gas cells.
//
// Input channel (in_valid/in_ready): one cell per transaction, density, three
// momenta and total energy in signed fixed point, plus last_cell. Result
// channel (out_valid/out_ready): one transaction after each cell marked
// last_cell, carrying the largest signal speed of the set, the density,
// absolute velocities and sound speed of the cell that gave it, and a sticky
// error flag. The block then clears its running state.
// Configuration (cfg_we/cfg_index/cfg_wdata) must be written by the user only
// while the block idles; the block itself does not enforce this. Per cell,
// three velocity divides, one pressure divide and one 31-step square root run
// one bit per cycle through the shared serial unit, and the products go
// through one registered 32x32 multiplier. A cell with non-positive density
// goes from the start state straight to the finish state; negative unclamped
// pressure skips the divide and square root. in_ready is high only while idle.
// A result waits in the output register; the next cells are still taken, and
// a later last cell holds until the receiver has taken the previous result.
// Reset restores the register defaults and clears the running maximum.
module euler_cfl_max_speed_reduce #(
  parameter int FRAC_BITS = ecfl_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_density,
  input  logic signed [31:0] in_mom_x,
  input  logic signed [31:0] in_mom_y,
  input  logic signed [31:0] in_mom_z,
  input  logic signed [31:0] in_energy,
  input  logic               in_last_cell,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        out_max_speed,
  output logic signed [31:0] out_at_density,
  output logic [30:0]        out_at_vel_x,
  output logic [30:0]        out_at_vel_y,
  output logic [30:0]        out_at_vel_z,
  output logic [30:0]        out_at_sound_speed,
  output logic               out_bad_cell,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata
);

  localparam int NW    = 32 + FRAC_BITS;
  localparam int SW    = ecfl_pkg::SQ_W;
  localparam int AW    = ecfl_pkg::ACC_W;
  localparam int GF    = ecfl_pkg::GAMMA_FRAC;
  localparam int S_SH  = 2 * FRAC_BITS + 1;
  localparam int XHI   = GF + 62 - FRAC_BITS - 1;
  localparam logic [AW-1:0]     EK_CAP = AW'(1) << ecfl_pkg::EK_CAP_BIT;
  localparam logic signed [50:0] D_CAP = 51'sd1 <<< ecfl_pkg::DIFF_CAP_BIT;

  ecfl_pkg::state_t state_r, state_nxt;

  // configuration
  logic [13:0] gamma_r;
  logic        speed_mode_r;
  logic        clamp_r;
  logic [30:0] floor_r;

  // cell operands and intermediates
  logic [31:0] dens_r;
  logic [31:0] amx_r, amy_r, amz_r;
  logic [31:0] energy_r;
  logic        last_r;
  logic [30:0] vx_r, vy_r, vz_r, cs_r, p_r;
  logic [63:0] sum_r;
  logic [AW-1:0] acc_r;
  logic [47:0] dmag_r;
  logic [13:0] gmag_r;
  logic        pneg_r;
  logic [NW-1:0] r_r;
  logic [63:0] mul_p_r;

  // running state
  logic [30:0] best_speed_r;
  logic [31:0] best_dens_r;
  logic [30:0] best_vx_r, best_vy_r, best_vz_r, best_cs_r;
  logic        error_seen_r;

  // result register
  logic        out_valid_r;
  logic [30:0] out_speed_r;
  logic [31:0] out_dens_r;
  logic [30:0] out_vx_r, out_vy_r, out_vz_r, out_cs_r;
  logic        out_bad_r;

  // shared unit
  ecfl_pkg::iter_cmd_t iter_cmd;
  logic [SW-1:0] iter_opnd;
  logic          iter_done;
  logic [NW-1:0] iter_q;

  logic [31:0] mul_a, mul_b;
  logic        in_ready_c;
  logic        err_now;
  logic        emit;

  // datapath helpers
  logic        rho_pos;
  logic        vel_sat;
  logic [30:0] vel_val;
  logic [AW-1:0] ek_full;
  logic [48:0] ek;
  logic signed [50:0] diff_w, diff_c;
  logic [50:0] dmag_w;
  logic signed [14:0] g1_w;
  logic [14:0] g1_mag;
  logic [61:0] m_mag;
  logic [62:0] p_ceil_w;
  logic signed [51:0] p_s, p1;
  logic        p_over, p_neg;
  logic [30:0] p_fin;
  logic        x_sat;
  logic [30:0] vmax;
  logic [32:0] cs3;
  logic [33:0] cand_w;
  logic        cand_over;
  logic [30:0] cand;

  ecfl_iter_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_iter (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (iter_cmd),
    .opnd (iter_opnd),
    .den  (dens_r[30:0]),
    .done (iter_done),
    .q    (iter_q)
  );

  always_comb begin
    rho_pos = !dens_r[31] && (|dens_r[30:0]);
    vel_sat = |iter_q[NW-1:31];
    vel_val = vel_sat ? ecfl_pkg::MAX31 : iter_q[30:0];

    ek_full = acc_r >> S_SH;
    ek      = (ek_full > EK_CAP) ? EK_CAP[48:0] : ek_full[48:0];
    diff_w  = $signed({{19{energy_r[31]}}, energy_r}) - $signed({2'b00, ek});
    if (diff_w > D_CAP) begin
      diff_c = D_CAP;
    end else if (diff_w < -D_CAP) begin
      diff_c = -D_CAP;
    end else begin
      diff_c = diff_w;
    end
    dmag_w = diff_c[50] ? 51'(-diff_c) : 51'(diff_c);
    g1_w   = $signed({1'b0, gamma_r}) - $signed(ecfl_pkg::GAMMA_ONE);
    g1_mag = g1_w[14] ? 15'(-g1_w) : 15'(g1_w);

    m_mag    = acc_r[61:0];
    p_ceil_w = {1'b0, m_mag} + 63'(ecfl_pkg::GAMMA_ONE - 15'd1);
    p_s      = pneg_r ? -$signed({1'b0, p_ceil_w[62:GF]})
                      : $signed({2'b00, m_mag[61:GF]});
    p_over   = p_s > $signed({21'd0, ecfl_pkg::MAX31});
    p1       = p_over ? $signed({21'd0, ecfl_pkg::MAX31}) : p_s;
    p_neg    = 1'b0;
    p_fin    = p1[30:0];
    if (clamp_r && (p1 < $signed({21'd0, floor_r}))) begin
      p_fin = floor_r;
    end else if (p1[51]) begin
      p_neg = 1'b1;
    end

    x_sat = |acc_r[AW-1:XHI+1];

    vmax = (vx_r > vy_r) ? vx_r : vy_r;
    vmax = (vz_r > vmax) ? vz_r : vmax;
    cs3  = {2'b00, cs_r} + {1'b0, cs_r, 1'b0};
    if (speed_mode_r) begin
      cand_w = 34'(vx_r) + 34'(vy_r) + 34'(vz_r) + 34'(cs3);
    end else begin
      cand_w = 34'(vmax) + 34'(cs_r);
    end
    cand_over = cand_w > 34'(ecfl_pkg::MAX31);
    cand      = cand_over ? ecfl_pkg::MAX31 : cand_w[30:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ecfl_pkg::ST_IDLE:      if (in_valid) state_nxt = ecfl_pkg::ST_START;
      ecfl_pkg::ST_START:     state_nxt = rho_pos ? ecfl_pkg::ST_VX_GO : ecfl_pkg::ST_FINISH;
      ecfl_pkg::ST_VX_GO:     state_nxt = ecfl_pkg::ST_VX_WAIT;
      ecfl_pkg::ST_VX_WAIT:   if (iter_done) state_nxt = ecfl_pkg::ST_VY_GO;
      ecfl_pkg::ST_VY_GO:     state_nxt = ecfl_pkg::ST_VY_WAIT;
      ecfl_pkg::ST_VY_WAIT:   if (iter_done) state_nxt = ecfl_pkg::ST_VZ_GO;
      ecfl_pkg::ST_VZ_GO:     state_nxt = ecfl_pkg::ST_VZ_WAIT;
      ecfl_pkg::ST_VZ_WAIT:   if (iter_done) state_nxt = ecfl_pkg::ST_SQ_X;
      ecfl_pkg::ST_SQ_X:      state_nxt = ecfl_pkg::ST_SQ_Y;
      ecfl_pkg::ST_SQ_Y:      state_nxt = ecfl_pkg::ST_SQ_Z;
      ecfl_pkg::ST_SQ_Z:      state_nxt = ecfl_pkg::ST_SUM_Z;
      ecfl_pkg::ST_SUM_Z:     state_nxt = ecfl_pkg::ST_EK_LO;
      ecfl_pkg::ST_EK_LO:     state_nxt = ecfl_pkg::ST_EK_HI;
      ecfl_pkg::ST_EK_HI:     state_nxt = ecfl_pkg::ST_EK_ACC;
      ecfl_pkg::ST_EK_ACC:    state_nxt = ecfl_pkg::ST_DIFF;
      ecfl_pkg::ST_DIFF:      state_nxt = ecfl_pkg::ST_PR_LO;
      ecfl_pkg::ST_PR_LO:     state_nxt = ecfl_pkg::ST_PR_HI;
      ecfl_pkg::ST_PR_HI:     state_nxt = ecfl_pkg::ST_PR_ACC;
      ecfl_pkg::ST_PR_ACC:    state_nxt = ecfl_pkg::ST_PRES;
      ecfl_pkg::ST_PRES:      state_nxt = p_neg ? ecfl_pkg::ST_CAND : ecfl_pkg::ST_R_GO;
      ecfl_pkg::ST_R_GO:      state_nxt = ecfl_pkg::ST_R_WAIT;
      ecfl_pkg::ST_R_WAIT:    if (iter_done) state_nxt = ecfl_pkg::ST_X_LO;
      ecfl_pkg::ST_X_LO:      state_nxt = ecfl_pkg::ST_X_HI;
      ecfl_pkg::ST_X_HI:      state_nxt = ecfl_pkg::ST_X_ACC;
      ecfl_pkg::ST_X_ACC:     state_nxt = ecfl_pkg::ST_X_CHK;
      ecfl_pkg::ST_X_CHK:     state_nxt = x_sat ? ecfl_pkg::ST_CAND : ecfl_pkg::ST_SQRT_GO;
      ecfl_pkg::ST_SQRT_GO:   state_nxt = ecfl_pkg::ST_SQRT_WAIT;
      ecfl_pkg::ST_SQRT_WAIT: if (iter_done) state_nxt = ecfl_pkg::ST_CAND;
      ecfl_pkg::ST_CAND:      state_nxt = ecfl_pkg::ST_FINISH;
      ecfl_pkg::ST_FINISH: begin
        if (!last_r || !out_valid_r || out_ready) state_nxt = ecfl_pkg::ST_IDLE;
      end
      default:                state_nxt = ecfl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_c = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    iter_cmd   = '0;
    iter_opnd  = '0;
    err_now    = 1'b0;
    emit       = 1'b0;
    unique case (state_r)
      ecfl_pkg::ST_IDLE:  in_ready_c = 1'b1;
      ecfl_pkg::ST_START: err_now = !rho_pos;
      ecfl_pkg::ST_VX_GO: begin
        iter_cmd.start = 1'b1;
        iter_opnd      = SW'(amx_r) << (SW - 32);
      end
      ecfl_pkg::ST_VY_GO: begin
        iter_cmd.start = 1'b1;
        iter_opnd      = SW'(amy_r) << (SW - 32);
      end
      ecfl_pkg::ST_VZ_GO: begin
        iter_cmd.start = 1'b1;
        iter_opnd      = SW'(amz_r) << (SW - 32);
      end
      ecfl_pkg::ST_VX_WAIT,
      ecfl_pkg::ST_VY_WAIT,
      ecfl_pkg::ST_VZ_WAIT: err_now = iter_done && vel_sat;
      ecfl_pkg::ST_SQ_X: begin
        mul_a = 32'(vx_r);
        mul_b = 32'(vx_r);
      end
      ecfl_pkg::ST_SQ_Y: begin
        mul_a = 32'(vy_r);
        mul_b = 32'(vy_r);
      end
      ecfl_pkg::ST_SQ_Z: begin
        mul_a = 32'(vz_r);
        mul_b = 32'(vz_r);
      end
      ecfl_pkg::ST_EK_LO: begin
        mul_a = 32'(dens_r[30:0]);
        mul_b = sum_r[31:0];
      end
      ecfl_pkg::ST_EK_HI: begin
        mul_a = 32'(dens_r[30:0]);
        mul_b = sum_r[63:32];
      end
      ecfl_pkg::ST_PR_LO: begin
        mul_a = dmag_r[31:0];
        mul_b = 32'(gmag_r);
      end
      ecfl_pkg::ST_PR_HI: begin
        mul_a = 32'(dmag_r[47:32]);
        mul_b = 32'(gmag_r);
      end
      ecfl_pkg::ST_PRES: err_now = p_over || p_neg;
      ecfl_pkg::ST_R_GO: begin
        iter_cmd.start = 1'b1;
        iter_opnd      = SW'(p_r) << (SW - 32);
      end
      ecfl_pkg::ST_X_LO: begin
        mul_a = r_r[31:0];
        mul_b = 32'(gamma_r);
      end
      ecfl_pkg::ST_X_HI: begin
        mul_a = 32'(r_r[NW-1:32]);
        mul_b = 32'(gamma_r);
      end
      ecfl_pkg::ST_X_CHK: err_now = x_sat;
      ecfl_pkg::ST_SQRT_GO: begin
        iter_cmd.start   = 1'b1;
        iter_cmd.is_sqrt = 1'b1;
        iter_opnd        = SW'(acc_r[XHI:GF]) << FRAC_BITS;
      end
      ecfl_pkg::ST_CAND:   err_now = cand_over;
      ecfl_pkg::ST_FINISH: emit = last_r && (!out_valid_r || out_ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r      <= ecfl_pkg::GAMMA_RST;
      speed_mode_r <= 1'b0;
      clamp_r      <= 1'b0;
      floor_r      <= ecfl_pkg::P_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ecfl_pkg::CFG_GAMMA:      gamma_r      <= cfg_wdata[13:0];
        ecfl_pkg::CFG_SPEED_MODE: speed_mode_r <= cfg_wdata[0];
        ecfl_pkg::CFG_CLAMP:      clamp_r      <= cfg_wdata[0];
        ecfl_pkg::CFG_FLOOR:      floor_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ecfl_pkg::ST_IDLE;
      best_speed_r <= '0;
      best_dens_r  <= '0;
      best_vx_r    <= '0;
      best_vy_r    <= '0;
      best_vz_r    <= '0;
      best_cs_r    <= '0;
      error_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        best_speed_r <= '0;
        best_dens_r  <= '0;
        best_vx_r    <= '0;
        best_vy_r    <= '0;
        best_vz_r    <= '0;
        best_cs_r    <= '0;
        error_seen_r <= 1'b0;
      end else begin
        if (err_now) error_seen_r <= 1'b1;
        if ((state_r == ecfl_pkg::ST_CAND) && (cand > best_speed_r)) begin
          best_speed_r <= cand;
          best_dens_r  <= dens_r;
          best_vx_r    <= vx_r;
          best_vy_r    <= vy_r;
          best_vz_r    <= vz_r;
          best_cs_r    <= cs_r;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_speed_r <= best_speed_r;
      out_dens_r  <= best_dens_r;
      out_vx_r    <= best_vx_r;
      out_vy_r    <= best_vy_r;
      out_vz_r    <= best_vz_r;
      out_cs_r    <= best_cs_r;
      out_bad_r   <= error_seen_r;
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= 64'(mul_a) * 64'(mul_b);
    if (in_valid && in_ready_c) begin
      dens_r   <= in_density;
      amx_r    <= in_mom_x[31] ? 32'(-in_mom_x) : in_mom_x;
      amy_r    <= in_mom_y[31] ? 32'(-in_mom_y) : in_mom_y;
      amz_r    <= in_mom_z[31] ? 32'(-in_mom_z) : in_mom_z;
      energy_r <= in_energy;
      last_r   <= in_last_cell;
    end
    unique case (state_r)
      ecfl_pkg::ST_VX_WAIT:   if (iter_done) vx_r <= vel_val;
      ecfl_pkg::ST_VY_WAIT:   if (iter_done) vy_r <= vel_val;
      ecfl_pkg::ST_VZ_WAIT:   if (iter_done) vz_r <= vel_val;
      ecfl_pkg::ST_SQ_Y:      sum_r <= mul_p_r;
      ecfl_pkg::ST_SQ_Z,
      ecfl_pkg::ST_SUM_Z:     sum_r <= sum_r + mul_p_r;
      ecfl_pkg::ST_EK_HI,
      ecfl_pkg::ST_PR_HI,
      ecfl_pkg::ST_X_HI:      acc_r <= AW'(mul_p_r);
      ecfl_pkg::ST_EK_ACC,
      ecfl_pkg::ST_PR_ACC,
      ecfl_pkg::ST_X_ACC:     acc_r <= acc_r + AW'({mul_p_r, 32'd0});
      ecfl_pkg::ST_DIFF: begin
        dmag_r <= dmag_w[47:0];
        gmag_r <= g1_mag[13:0];
        pneg_r <= diff_c[50] ^ g1_w[14];
      end
      ecfl_pkg::ST_PRES: begin
        p_r <= p_fin;
        if (p_neg) cs_r <= '0;
      end
      ecfl_pkg::ST_R_WAIT:    if (iter_done) r_r <= iter_q;
      ecfl_pkg::ST_X_CHK:     if (x_sat) cs_r <= ecfl_pkg::MAX31;
      ecfl_pkg::ST_SQRT_WAIT: if (iter_done) cs_r <= iter_q[30:0];
      default: ;
    endcase
  end

  assign in_ready           = in_ready_c;
  assign out_valid          = out_valid_r;
  assign out_max_speed      = out_speed_r;
  assign out_at_density     = out_dens_r;
  assign out_at_vel_x       = out_vx_r;
  assign out_at_vel_y       = out_vy_r;
  assign out_at_vel_z       = out_vz_r;
  assign out_at_sound_speed = out_cs_r;
  assign out_bad_cell       = out_bad_r;

endmodule

// ===== hw/rtl/ecfl_iter_unit.sv =====
// Shared bit-serial unit: restoring divide or integer square root, one bit per cycle.
module ecfl_iter_unit #(
  parameter int FRAC_BITS = ecfl_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ecfl_pkg::iter_cmd_t         cmd,
  input  logic [ecfl_pkg::SQ_W-1:0]   opnd,
  input  logic [30:0]                 den,
  output logic                        done,
  output logic [32+FRAC_BITS-1:0]     q
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int SW = ecfl_pkg::SQ_W;
  localparam int RW = ecfl_pkg::REM_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic          sqrt_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] sh_r;
  logic [RW-1:0] rem_r;
  logic [NW-1:0] q_r;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;
  logic [RW-1:0] rem_nxt;

  always_comb begin
    if (sqrt_r) begin
      rem_sh = {rem_r[RW-3:0], sh_r[SW-1:SW-2]};
      trial  = {q_r[RW-3:0], 2'b01};
    end else begin
      rem_sh = {rem_r[RW-2:0], sh_r[SW-1]};
      trial  = RW'(den);
    end
    ge      = rem_sh >= trial;
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= cmd.is_sqrt ? CW'(ecfl_pkg::SQRT_STEPS) : CW'(NW);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CW'(1);
      busy_r <= (cnt_r != CW'(1));
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sqrt_r <= cmd.is_sqrt;
      sh_r   <= opnd;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      sh_r  <= sqrt_r ? (sh_r << 2) : (sh_r << 1);
      rem_r <= rem_nxt;
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== dv/euler_cfl_max_speed_reduce_test.sv =====
// Testbench of the CFL maximum signal speed reducer: directed and random cells against a built-in predictor.
`timescale 1ns / 1ps

module euler_cfl_max_speed_reduce_test;

  typedef struct packed {
    logic [31:0] density;
    logic [31:0] mom_x;
    logic [31:0] mom_y;
    logic [31:0] mom_z;
    logic [31:0] energy;
    logic        last_cell;
  } cell_t;

  typedef struct packed {
    logic [30:0] max_speed;
    logic [31:0] at_density;
    logic [30:0] at_vel_x;
    logic [30:0] at_vel_y;
    logic [30:0] at_vel_z;
    logic [30:0] at_sound_speed;
    logic        bad_cell;
  } speed_rpt_t;

  localparam longint LIMIT = 2000000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] in_density = 0, in_mom_x = 0, in_mom_y = 0, in_mom_z = 0, in_energy = 0;
  logic in_last_cell = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [30:0] out_max_speed, out_at_vel_x, out_at_vel_y, out_at_vel_z, out_at_sound_speed;
  logic signed [31:0] out_at_density;
  logic out_bad_cell;
  logic cfg_we = 0;
  logic [1:0] cfg_index = ecfl_pkg::CFG_GAMMA;
  logic [30:0] cfg_wdata = 0;

  euler_cfl_max_speed_reduce dut (.*);

  cell_t      pending_cells[$];
  speed_rpt_t expected_rpts[$];
  int         errors = 0;
  longint     cycles = 0;
  int         in_gap = 0;
  int         out_gap = 0;
  logic       in_taken = 0;
  logic       out_taken = 0;

  // shadow configuration and running maximum
  logic [13:0] m_gamma;
  logic        m_mode, m_clamp;
  logic [30:0] m_floor;
  logic [63:0] m_best;
  logic [31:0] m_best_rho;
  logic [63:0] m_best_vx, m_best_vy, m_best_vz, m_best_cs;
  logic        m_err;

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 4);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs_vel(logic [31:0] m, logic [63:0] rho, ref logic err);
    logic [63:0] a, q;
    a = m[31] ? 64'(-$signed({32'hFFFF_FFFF, m})) : {32'd0, m};
    q = (a << 16) / rho;
    if (q > 64'(ecfl_pkg::MAX31)) begin
      q = 64'(ecfl_pkg::MAX31);
      err = 1;
    end
    return q;
  endfunction

  task automatic clear_best();
    m_best = 0; m_best_rho = 0; m_best_vx = 0; m_best_vy = 0; m_best_vz = 0;
    m_best_cs = 0; m_err = 0;
  endtask

  task automatic predict_cell(cell_t c);
    logic err, neg;
    logic [63:0] rho, vx, vy, vz, sq, a, b, cc, ek, cs, cand, r, x, mv;
    longint diff, p, e;
    speed_rpt_t rp;
    err = 0;
    neg = 0;
    if ($signed(c.density) > 0) begin
      rho = {32'd0, c.density};
      vx = abs_vel(c.mom_x, rho, err);
      vy = abs_vel(c.mom_y, rho, err);
      vz = abs_vel(c.mom_z, rho, err);
      e = longint'($signed(c.energy));
      sq = vx * vx + vy * vy + vz * vz;
      a = rho * (sq >> 32);
      b = rho * (sq & 64'hFFFF_FFFF);
      cc = a + (b >> 32);
      ek = cc >> 1;
      if (ek > (64'd1 << 48)) ek = 64'd1 << 48;
      diff = e - longint'(ek);
      if (diff > (64'sd1 <<< 47)) diff = 64'sd1 <<< 47;
      if (diff < -(64'sd1 <<< 47)) diff = -(64'sd1 <<< 47);
      p = diff * (longint'(m_gamma) - 4096);
      p = p >>> 12;
      if (p > longint'(ecfl_pkg::MAX31)) begin
        p = longint'(ecfl_pkg::MAX31);
        err = 1;
      end
      if (m_clamp && p < longint'(m_floor)) p = longint'(m_floor);
      else if (p < 0) begin
        err = 1;
        neg = 1;
      end
      if (neg) cs = 0;
      else begin
        r = (64'(p) << 16) / rho;
        x = (r >> 12) * m_gamma + (((r & 64'd4095) * m_gamma) >> 12);
        if (x >= (64'd1 << 46)) begin
          cs = 64'(ecfl_pkg::MAX31);
          err = 1;
        end else begin
          cs = isqrt(x << 16);
          if (cs > 64'(ecfl_pkg::MAX31)) begin
            cs = 64'(ecfl_pkg::MAX31);
            err = 1;
          end
        end
      end
      if (m_mode) cand = vx + vy + vz + 3 * cs;
      else begin
        mv = (vx > vy) ? vx : vy;
        mv = (vz > mv) ? vz : mv;
        cand = mv + cs;
      end
      if (cand > 64'(ecfl_pkg::MAX31)) begin
        cand = 64'(ecfl_pkg::MAX31);
        err = 1;
      end
      if (cand > m_best) begin
        m_best = cand; m_best_rho = c.density;
        m_best_vx = vx; m_best_vy = vy; m_best_vz = vz; m_best_cs = cs;
      end
    end else err = 1;
    if (err) m_err = 1;
    if (c.last_cell) begin
      rp.max_speed = m_best[30:0];
      rp.at_density = m_best_rho;
      rp.at_vel_x = m_best_vx[30:0];
      rp.at_vel_y = m_best_vy[30:0];
      rp.at_vel_z = m_best_vz[30:0];
      rp.at_sound_speed = m_best_cs[30:0];
      rp.bad_cell = m_err;
      expected_rpts.push_back(rp);
      clear_best();
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_valid <= 0;
        in_gap <= rand_gap();
      end else if (!in_valid && in_gap > 0) in_gap <= in_gap - 1;
      else if (!in_valid && pending_cells.size() > 0) begin
        in_density <= pending_cells[0].density;
        in_mom_x <= pending_cells[0].mom_x;
        in_mom_y <= pending_cells[0].mom_y;
        in_mom_z <= pending_cells[0].mom_z;
        in_energy <= pending_cells[0].energy;
        in_last_cell <= pending_cells[0].last_cell;
        void'(pending_cells.pop_front());
        in_valid <= 1;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 0;
      end else if (out_taken) begin
        out_gap <= rand_gap();
        out_ready <= 0;
      end else out_ready <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    speed_rpt_t e;
    in_taken <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready)
      predict_cell({in_density, in_mom_x, in_mom_y, in_mom_z, in_energy, in_last_cell});
    if (rst_n && out_valid && out_ready) begin
      if (expected_rpts.size() == 0) begin
        $display("unexpected result transaction");
        errors++;
      end else begin
        e = expected_rpts.pop_front();
        if (out_max_speed !== e.max_speed) report("max_speed", out_max_speed, e.max_speed);
        if (out_at_density !== e.at_density) report("at_density", out_at_density, e.at_density);
        if (out_at_vel_x !== e.at_vel_x) report("at_vel_x", out_at_vel_x, e.at_vel_x);
        if (out_at_vel_y !== e.at_vel_y) report("at_vel_y", out_at_vel_y, e.at_vel_y);
        if (out_at_vel_z !== e.at_vel_z) report("at_vel_z", out_at_vel_z, e.at_vel_z);
        if (out_at_sound_speed !== e.at_sound_speed)
          report("at_sound_speed", out_at_sound_speed, e.at_sound_speed);
        if (out_bad_cell !== e.bad_cell) report("bad_cell", out_bad_cell, e.bad_cell);
      end
    end
  end

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000);
      2: return -$urandom_range(0, 32'h0004_0000);
      3: return $urandom_range(0, 32'h0000_1000);
      4: return {1'b0, 31'h7FFF_FFFF};
      default: return $urandom_range(0, 32'h0100_0000);
    endcase
  endfunction

  function automatic cell_t rnd_cell(bit last);
    cell_t c;
    c.density = ($urandom_range(0, 9) == 0) ? rnd_word() : $urandom_range(32'h100, 32'h0080_0000);
    c.mom_x = rnd_word();
    c.mom_y = rnd_word();
    c.mom_z = rnd_word();
    c.energy = ($urandom_range(0, 3) == 0) ? rnd_word() : $urandom_range(0, 32'h7FFF_FFFF);
    c.last_cell = last;
    return c;
  endfunction

  task automatic push_cell(logic [31:0] d, logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                           logic [31:0] en, bit last);
    pending_cells.push_back({d, mx, my, mz, en, last});
  endtask

  task automatic drain();
    while (pending_cells.size() > 0 || in_valid || expected_rpts.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(ecfl_pkg::cfg_idx_t idx, logic [30:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      ecfl_pkg::CFG_GAMMA:      m_gamma = v[13:0];
      ecfl_pkg::CFG_SPEED_MODE: m_mode = v[0];
      ecfl_pkg::CFG_CLAMP:      m_clamp = v[0];
      default:                  m_floor = v;
    endcase
  endtask

  task automatic random_sets(int n);
    int k;
    for (k = 0; k < n; k++) pending_cells.push_back(rnd_cell($urandom_range(0, 3) == 0));
    pending_cells.push_back(rnd_cell(1));
  endtask

  initial begin
    m_gamma = ecfl_pkg::GAMMA_RST; m_mode = 0; m_clamp = 0; m_floor = ecfl_pkg::P_FLOOR_RST;
    clear_best();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed cells
    push_cell(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0, 32'h0010_0000, 1);
    push_cell(32'h0, 32'h1, 32'h1, 32'h1, 32'h1, 0);
    push_cell(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1);
    push_cell(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1);
    push_cell(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1);
    push_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1);
    push_cell(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0004_0000, 0);
    push_cell(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0004_0000, 1);
    push_cell(32'h0000_0100, 32'hFFFF_FFFF, 32'h0000_00FF, 32'h8000_0001, 32'h7FFF_FFFF, 1);
    drain();
    write_cfg(ecfl_pkg::CFG_CLAMP, 31'd1);
    write_cfg(ecfl_pkg::CFG_FLOOR, 31'h7FFF_FFFF);
    push_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1);
    push_cell(32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 1);
    drain();
    write_cfg(ecfl_pkg::CFG_SPEED_MODE, 31'd1);
    write_cfg(ecfl_pkg::CFG_GAMMA, 31'd16383);
    write_cfg(ecfl_pkg::CFG_FLOOR, 31'd0);
    push_cell(32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0100_0000, 1);
    push_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1);
    drain();
    write_cfg(ecfl_pkg::CFG_GAMMA, 31'd0);
    write_cfg(ecfl_pkg::CFG_CLAMP, 31'd0);
    push_cell(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0100_0000, 1);
    push_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'hFF00_0000, 1);
    drain();

    // random phases through several settings
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(ecfl_pkg::CFG_GAMMA, (ph == 0) ? 31'd4096 : (ph == 1) ? 31'd16383 :
                                     31'($urandom_range(0, 16383)));
      write_cfg(ecfl_pkg::CFG_SPEED_MODE, 31'(ph & 1));
      write_cfg(ecfl_pkg::CFG_CLAMP, 31'((ph >> 1) & 1));
      write_cfg(ecfl_pkg::CFG_FLOOR,
                (ph == 3) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 32'h0010_0000)));
      random_sets(140);
      drain();
    end

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
